// File: rtl/bfa_pkg.sv
// Shared types, codes and defaults for the bitmap frame allocator.
package bfa_pkg;

  localparam int unsigned FRAMES_DEF  = 65536;
  localparam int unsigned DOMAINS_DEF = 4;
  localparam int unsigned MAX_RUN_DEF = 32;

  localparam int unsigned OFFW = 20;  // frame offset bits of a 32-bit address
  localparam int unsigned FCW  = 21;  // frame numbers up to and including 2^20

  localparam logic [31:0] BASE_RESET = 32'h8000_0000;

  localparam logic [2:0] MODE_ALLOC = 3'd0;
  localparam logic [2:0] MODE_CLAIM = 3'd1;
  localparam logic [2:0] MODE_FREE  = 3'd2;
  localparam logic [2:0] MODE_RANGE = 3'd3;
  localparam logic [2:0] MODE_QUERY = 3'd4;

  localparam logic [2:0] STS_OK     = 3'd0;
  localparam logic [2:0] STS_BADDOM = 3'd1;
  localparam logic [2:0] STS_NOFREE = 3'd2;
  localparam logic [2:0] STS_COUNT  = 3'd3;
  localparam logic [2:0] STS_USED   = 3'd4;
  localparam logic [2:0] STS_REV    = 3'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_SETUP,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_t;

endpackage

// File: rtl/bfa_bitmap_ram.sv
// Bitmap word memory: one write port, one registered read port.
module bfa_bitmap_ram #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bitmap_frame_allocator.sv
// Bitmap frame allocator top level: request sequencer around one bitmap word memory.
// Each request steps through prepare and setup, then a memory read and an evaluate for each
// bitmap word visited, then done; allocation visits up to FRAMES/DOMAINS/32 words,
// free range up to (FRAMES+31)/32 words, claim, free and query one word or none.
// Busy drops with the result strobe, so the next request can be taken in the strobe cycle.
// After reset the bitmap is cleared, one word per cycle, through all (FRAMES+31)/32 words
// with busy high; configuration writes are taken throughout. Results cannot be stalled.
module bitmap_frame_allocator #(
  parameter int unsigned FRAMES  = bfa_pkg::FRAMES_DEF,
  parameter int unsigned DOMAINS = bfa_pkg::DOMAINS_DEF,
  parameter int unsigned MAX_RUN = bfa_pkg::MAX_RUN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_domain,
  input  logic [7:0]  in_frame_count,
  input  logic [31:0] in_address,
  input  logic [31:0] in_last_address,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_frame_address,
  output logic        out_in_use,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_memory_base
);

  localparam int unsigned WORDS  = (FRAMES + 31) / 32;
  localparam int unsigned IW     = $clog2(WORDS);
  localparam int unsigned REGION = FRAMES / DOMAINS;
  localparam int unsigned OFFW   = bfa_pkg::OFFW;
  localparam int unsigned FCW    = bfa_pkg::FCW;

  bfa_pkg::state_t state_r, state_nxt;

  logic [31:0]     base_r;
  logic [2:0]      mode_r, mode_nxt;
  logic [7:0]      dom_r, dom_nxt;
  logic [7:0]      cnt_r, cnt_nxt;
  logic [31:0]     addr_r, addr_nxt;
  logic [31:0]     laddr_r, laddr_nxt;
  logic [OFFW-1:0] off_r, off_nxt;
  logic [OFFW-1:0] n_r, n_nxt;
  logic            rev_r, rev_nxt;
  logic [FCW-1:0]  lo_r, lo_nxt;
  logic [FCW-1:0]  hi_r, hi_nxt;
  logic            oob_r, oob_nxt;
  logic [IW-1:0]   word_r, word_nxt;
  logic            found_r, found_nxt;
  logic [2:0]      sts_r, sts_nxt;
  logic            use_r, use_nxt;

  logic            out_valid_r;
  logic [2:0]      out_status_r;
  logic [31:0]     out_faddr_r;
  logic            out_use_r;

  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic [31:0]     mem_wdata;
  logic [31:0]     mem_rdata;

  logic [31:0]     rel;
  logic [32:0]     diff;
  logic [FCW-1:0]  stop;
  logic [FCW-1:0]  dom_first;
  logic [31:0]     lomask, himask, mask, cand, sel, bitmask, runmask;
  logic [4:0]      pos;
  logic            last_word;

  bfa_bitmap_ram #(.DEPTH(WORDS), .AW(IW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (word_r),
    .rdata (mem_rdata)
  );

  // lowest set bit
  function automatic logic [4:0] first_one(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  assign rel       = addr_r - base_r;
  assign diff      = {1'b0, laddr_r} - {1'b0, addr_r};
  assign stop      = FCW'(off_r) + FCW'(n_r);
  assign dom_first = FCW'(dom_r[3:0] * FCW'(REGION));

  always_comb begin
    lomask = (word_r == lo_r[IW+4:5]) ? (32'hFFFF_FFFF << lo_r[4:0]) : 32'hFFFF_FFFF;
    himask = (word_r == hi_r[IW+4:5]) ? (32'hFFFF_FFFF >> (5'd31 - hi_r[4:0]))
                                      : 32'hFFFF_FFFF;
    mask      = lomask & himask;
    cand      = ~mem_rdata & mask;
    pos       = first_one(cand);
    sel       = 32'd1 << pos;
    bitmask   = 32'd1 << off_r[4:0];
    runmask   = 32'hFFFF_FFFF >> 6'(7'd32 - 7'(cnt_r));
    last_word = (word_r == hi_r[IW+4:5]);
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    dom_nxt   = dom_r;
    cnt_nxt   = cnt_r;
    addr_nxt  = addr_r;
    laddr_nxt = laddr_r;
    off_nxt   = off_r;
    n_nxt     = n_r;
    rev_nxt   = rev_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    oob_nxt   = oob_r;
    word_nxt  = word_r;
    found_nxt = found_r;
    sts_nxt   = sts_r;
    use_nxt   = use_r;
    mem_we    = 1'b0;
    mem_waddr = word_r;
    mem_wdata = '0;
    case (state_r)
      bfa_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        word_nxt  = word_r + 1'b1;
        if (word_r == IW'(WORDS - 1)) begin
          state_nxt = bfa_pkg::ST_IDLE;
        end
      end
      bfa_pkg::ST_IDLE: begin
        if (start) begin
          mode_nxt  = in_mode;
          dom_nxt   = in_domain;
          cnt_nxt   = in_frame_count;
          addr_nxt  = in_address;
          laddr_nxt = in_last_address;
          found_nxt = 1'b0;
          sts_nxt   = bfa_pkg::STS_OK;
          use_nxt   = 1'b0;
          state_nxt = bfa_pkg::ST_PREP;
        end
      end
      bfa_pkg::ST_PREP: begin
        // round up to the next frame
        off_nxt   = OFFW'((rel + 32'h0000_0FFF) >> 12);
        n_nxt     = diff[31:12];
        rev_nxt   = diff[32];
        state_nxt = bfa_pkg::ST_SETUP;
      end
      bfa_pkg::ST_SETUP: begin
        state_nxt = bfa_pkg::ST_DONE;
        case (mode_r)
          bfa_pkg::MODE_ALLOC: begin
            if (dom_r >= 8'(DOMAINS)) begin
              sts_nxt = bfa_pkg::STS_BADDOM;
            end else if (cnt_r > 8'(MAX_RUN)) begin
              sts_nxt = bfa_pkg::STS_COUNT;
            end else begin
              lo_nxt    = dom_first;
              hi_nxt    = dom_first + FCW'(REGION - 1);
              word_nxt  = dom_first[IW+4:5];
              state_nxt = bfa_pkg::ST_READ;
            end
          end
          bfa_pkg::MODE_CLAIM, bfa_pkg::MODE_FREE, bfa_pkg::MODE_QUERY: begin
            if (FCW'(off_r) >= FCW'(FRAMES)) begin
              if (mode_r == bfa_pkg::MODE_QUERY) use_nxt = 1'b1;
              else sts_nxt = bfa_pkg::STS_USED;
            end else begin
              word_nxt  = off_r[IW+4:5];
              state_nxt = bfa_pkg::ST_READ;
            end
          end
          bfa_pkg::MODE_RANGE: begin
            if (rev_r) begin
              sts_nxt = bfa_pkg::STS_REV;
            end else if (FCW'(off_r) >= FCW'(FRAMES)) begin
              sts_nxt = bfa_pkg::STS_USED;
            end else begin
              // clip the run at the last frame, flag the overrun
              lo_nxt    = FCW'(off_r);
              oob_nxt   = (stop >= FCW'(FRAMES));
              hi_nxt    = (stop >= FCW'(FRAMES)) ? FCW'(FRAMES - 1) : stop;
              word_nxt  = off_r[IW+4:5];
              state_nxt = bfa_pkg::ST_READ;
            end
          end
          default: begin
            sts_nxt = bfa_pkg::STS_USED;
          end
        endcase
      end
      bfa_pkg::ST_READ: begin
        state_nxt = bfa_pkg::ST_EVAL;
      end
      bfa_pkg::ST_EVAL: begin
        state_nxt = bfa_pkg::ST_DONE;
        case (mode_r)
          bfa_pkg::MODE_ALLOC: begin
            if (cnt_r <= 8'd1 && cand != '0) begin
              mem_we    = 1'b1;
              mem_wdata = mem_rdata | sel;
              off_nxt   = OFFW'({word_r, pos});
              found_nxt = 1'b1;
            end else if (cnt_r > 8'd1 && mask == 32'hFFFF_FFFF && mem_rdata == '0) begin
              mem_we    = 1'b1;
              mem_wdata = runmask;
              off_nxt   = OFFW'({word_r, 5'd0});
              found_nxt = 1'b1;
            end else if (last_word) begin
              sts_nxt = bfa_pkg::STS_NOFREE;
            end else begin
              word_nxt  = word_r + 1'b1;
              state_nxt = bfa_pkg::ST_READ;
            end
          end
          bfa_pkg::MODE_CLAIM: begin
            if ((mem_rdata & bitmask) != '0) begin
              sts_nxt = bfa_pkg::STS_USED;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = mem_rdata | bitmask;
              found_nxt = 1'b1;
            end
          end
          bfa_pkg::MODE_FREE: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata & ~bitmask;
          end
          bfa_pkg::MODE_QUERY: begin
            use_nxt = ((mem_rdata & bitmask) != '0);
          end
          bfa_pkg::MODE_RANGE: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata & ~mask;
            if (last_word) begin
              if (oob_r) sts_nxt = bfa_pkg::STS_USED;
            end else begin
              word_nxt  = word_r + 1'b1;
              state_nxt = bfa_pkg::ST_READ;
            end
          end
          default: begin
            sts_nxt = bfa_pkg::STS_USED;
          end
        endcase
      end
      bfa_pkg::ST_DONE: begin
        state_nxt = bfa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfa_pkg::ST_CLEAR;
      word_r      <= '0;
      base_r      <= bfa_pkg::BASE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      out_valid_r <= (state_r == bfa_pkg::ST_DONE);
      if (cfg_valid) begin
        base_r <= cfg_memory_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    dom_r   <= dom_nxt;
    cnt_r   <= cnt_nxt;
    addr_r  <= addr_nxt;
    laddr_r <= laddr_nxt;
    off_r   <= off_nxt;
    n_r     <= n_nxt;
    rev_r   <= rev_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    oob_r   <= oob_nxt;
    found_r <= found_nxt;
    sts_r   <= sts_nxt;
    use_r   <= use_nxt;
    if (state_r == bfa_pkg::ST_DONE) begin
      out_status_r <= sts_r;
      out_use_r    <= use_r;
      out_faddr_r  <= found_r ? ({off_r, 12'h000} + base_r) : 32'd0;
    end
  end

  assign busy              = (state_r != bfa_pkg::ST_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_frame_address = out_faddr_r;
  assign out_in_use        = out_use_r;

`ifndef SYNTH
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");
  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bfa_pkg::STS_OK |-> out_frame_address == 32'd0)
    else $error("failed request returned a frame address");
  a_use_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_use |-> out_status == bfa_pkg::STS_OK)
    else $error("query in-use flag with error status");
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");
`endif

endmodule

// File: dv/tb_bitmap_frame_allocator.sv
// Self-checking testbench for the bitmap frame allocator: directed table, domain fill, random traffic.
module tb_bitmap_frame_allocator;

  localparam int unsigned FRAMES  = bfa_pkg::FRAMES_DEF;
  localparam int unsigned DOMAINS = bfa_pkg::DOMAINS_DEF;
  localparam int unsigned MAX_RUN = bfa_pkg::MAX_RUN_DEF;
  localparam int unsigned WORDS   = (FRAMES + 31) / 32;
  localparam int unsigned REGION  = FRAMES / DOMAINS;
  localparam logic [2:0] MODE_BAD_LO = 3'd5;
  localparam logic [2:0] MODE_BAD_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] frame_address;
    logic        in_use;
  } alloc_result_t;

  typedef struct {
    logic [2:0]    mode;
    logic [7:0]    domain;
    logic [7:0]    frame_count;
    logic [31:0]   address;
    logic [31:0]   last_address;
    bit            typed;
    alloc_result_t want;
  } request_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_mode = '0;
  logic [7:0]  in_domain = '0;
  logic [7:0]  in_frame_count = '0;
  logic [31:0] in_address = '0;
  logic [31:0] in_last_address = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_frame_address;
  logic        out_in_use;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_memory_base = '0;

  bitmap_frame_allocator u_top (.*);

  always #2 clk = ~clk;

  // shadow state
  logic [31:0]   used_words[WORDS];
  logic [31:0]   base_addr;
  alloc_result_t pending_results[$];
  int            error_count = 0;
  int            idle_pct = 0;

  function automatic logic [31:0] addr_to_frame(logic [31:0] a);
    logic [31:0] rel;
    rel = ((a - base_addr) + 32'hFFF) & ~32'hFFF;
    return rel >> 12;
  endfunction

  function automatic logic [31:0] frame_to_addr(logic [31:0] f);
    return (f << 12) + base_addr;
  endfunction

  function automatic bit frame_taken(logic [31:0] f);
    if (f >= FRAMES) return 1'b1;
    return used_words[f >> 5][f[4:0]];
  endfunction

  function automatic alloc_result_t predict_request(logic [2:0] mode, logic [7:0] dom,
                                                    logic [7:0] cnt, logic [31:0] a,
                                                    logic [31:0] la);
    alloc_result_t r;
    logic [31:0] lo, hi, f, stop;
    bit found;
    r = '0;
    found = 0;
    case (mode)
      bfa_pkg::MODE_ALLOC: begin
        if (dom >= DOMAINS) r.status = bfa_pkg::STS_BADDOM;
        else if (cnt > MAX_RUN) r.status = bfa_pkg::STS_COUNT;
        else begin
          lo = dom * REGION;
          hi = lo + REGION - 1;
          for (int w = lo >> 5; w <= (hi >> 5) && !found; w++) begin
            if (cnt <= 1) begin
              for (int b = 0; b < 32 && !found; b++) begin
                f = (w << 5) + b;
                if (f >= lo && f <= hi && !used_words[w][b]) begin
                  used_words[w][b] = 1'b1;
                  r.frame_address = frame_to_addr(f);
                  found = 1;
                end
              end
            end else if ((w << 5) >= lo && (w << 5) + 31 <= hi && used_words[w] == '0) begin
              used_words[w] = 32'hFFFF_FFFF >> (32 - cnt);
              r.frame_address = frame_to_addr(w << 5);
              found = 1;
            end
          end
          if (!found) r.status = bfa_pkg::STS_NOFREE;
        end
      end
      bfa_pkg::MODE_CLAIM: begin
        f = addr_to_frame(a);
        if (frame_taken(f)) r.status = bfa_pkg::STS_USED;
        else begin
          used_words[f >> 5][f[4:0]] = 1'b1;
          r.frame_address = frame_to_addr(f);
        end
      end
      bfa_pkg::MODE_FREE: begin
        f = addr_to_frame(a);
        if (f >= FRAMES) r.status = bfa_pkg::STS_USED;
        else used_words[f >> 5][f[4:0]] = 1'b0;
      end
      bfa_pkg::MODE_RANGE: begin
        if (la < a) r.status = bfa_pkg::STS_REV;
        else begin
          f = addr_to_frame(a);
          stop = f + ((la - a) >> 12);
          forever begin
            if (f >= FRAMES) begin
              r.status = bfa_pkg::STS_USED;
              break;
            end
            used_words[f >> 5][f[4:0]] = 1'b0;
            if (f == stop) break;
            f++;
          end
        end
      end
      bfa_pkg::MODE_QUERY: r.in_use = frame_taken(addr_to_frame(a));
      default: r.status = bfa_pkg::STS_USED;
    endcase
    return r;
  endfunction

  task automatic send_request(request_row_t rq);
    alloc_result_t p;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    in_mode         <= rq.mode;
    in_domain       <= rq.domain;
    in_frame_count  <= rq.frame_count;
    in_address      <= rq.address;
    in_last_address <= rq.last_address;
    do @(posedge clk); while (busy);
    p = predict_request(rq.mode, rq.domain, rq.frame_count, rq.address, rq.last_address);
    if (rq.typed && p !== rq.want) begin
      $display("%0t: table row mismatch: expected %h actual prediction %h",
               $time, rq.want, p);
      error_count++;
    end
    pending_results.push_back(p);
    @(negedge clk);
  endtask

  // every request yields a result, so an empty queue means the block is idle
  task automatic drain_and_set_base(logic [31:0] v);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (10) @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_memory_base <= v;
    do @(posedge clk); while (!cfg_ready);
    base_addr = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic request_row_t mk(logic [2:0] m, logic [7:0] d, logic [7:0] c,
                                      logic [31:0] a, logic [31:0] la, bit typed,
                                      logic [2:0] s, logic [31:0] fa, logic iu);
    request_row_t rq;
    rq.mode = m; rq.domain = d; rq.frame_count = c;
    rq.address = a; rq.last_address = la;
    rq.typed = typed;
    rq.want.status = s; rq.want.frame_address = fa; rq.want.in_use = iu;
    return rq;
  endfunction

  function automatic logic [31:0] pick_address();
    logic [31:0] f;
    if ($urandom_range(3) == 0) return $urandom;
    if ($urandom_range(1)) f = $urandom_range(DOMAINS - 1) * REGION + $urandom_range(100);
    else f = $urandom_range(FRAMES + 40);
    return base_addr + (f << 12) - ($urandom_range(1) ? 32'd0 : 32'($urandom_range(4095)));
  endfunction

  function automatic request_row_t random_request();
    request_row_t rq;
    int pick;
    rq = mk(bfa_pkg::MODE_ALLOC, 0, 0, 0, 0, 0, bfa_pkg::STS_OK, 0, 0);
    pick = $urandom_range(99);
    if (pick < 30) rq.mode = bfa_pkg::MODE_ALLOC;
    else if (pick < 45) rq.mode = bfa_pkg::MODE_CLAIM;
    else if (pick < 60) rq.mode = bfa_pkg::MODE_FREE;
    else if (pick < 77) rq.mode = bfa_pkg::MODE_RANGE;
    else if (pick < 94) rq.mode = bfa_pkg::MODE_QUERY;
    else rq.mode = 3'($urandom_range(MODE_BAD_HI, MODE_BAD_LO));
    rq.domain = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(DOMAINS - 1));
    rq.frame_count = ($urandom_range(9) == 0) ? 8'($urandom)
                   : ($urandom_range(1) ? 8'($urandom_range(1)) : 8'($urandom_range(MAX_RUN)));
    rq.address = pick_address();
    if ($urandom_range(9) == 0) rq.last_address = $urandom;
    else rq.last_address = rq.address + ($urandom_range(40) << 12) + $urandom_range(4095);
    return rq;
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none actual %0d %h %0d", $time,
                 out_status, out_frame_address, out_in_use);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status: expected %0d actual %0d", $time, want.status, out_status);
          error_count++;
        end
        if (out_frame_address !== want.frame_address) begin
          $display("%0t: frame_address: expected %h actual %h", $time,
                   want.frame_address, out_frame_address);
          error_count++;
        end
        if (out_in_use !== want.in_use) begin
          $display("%0t: in_use: expected %0d actual %0d", $time, want.in_use, out_in_use);
          error_count++;
        end
      end
    end
  end

  initial begin
    #40000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    request_row_t rows[$];
    foreach (used_words[i]) used_words[i] = '0;
    base_addr = bfa_pkg::BASE_RESET;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    rows = '{
      mk(bfa_pkg::MODE_ALLOC, 0, 0, 0, 0, 1, bfa_pkg::STS_OK, 32'h8000_0000, 0),
      mk(bfa_pkg::MODE_ALLOC, 0, 1, 0, 0, 1, bfa_pkg::STS_OK, 32'h8000_1000, 0),
      mk(bfa_pkg::MODE_ALLOC, 4, 1, 0, 0, 1, bfa_pkg::STS_BADDOM, 0, 0),
      mk(bfa_pkg::MODE_ALLOC, 255, 255, 0, 0, 1, bfa_pkg::STS_BADDOM, 0, 0),
      mk(bfa_pkg::MODE_ALLOC, 1, 33, 0, 0, 1, bfa_pkg::STS_COUNT, 0, 0),
      mk(bfa_pkg::MODE_ALLOC, 1, 255, 0, 0, 1, bfa_pkg::STS_COUNT, 0, 0),
      mk(bfa_pkg::MODE_ALLOC, 1, 2, 0, 0, 1, bfa_pkg::STS_OK, 32'h8400_0000, 0),
      mk(bfa_pkg::MODE_ALLOC, 3, 32, 0, 0, 0, bfa_pkg::STS_OK, 0, 0),
      mk(bfa_pkg::MODE_CLAIM, 0, 0, 32'h8000_0000, 0, 1, bfa_pkg::STS_USED, 0, 0),
      mk(bfa_pkg::MODE_CLAIM, 0, 0, 32'h8000_5000, 0, 1, bfa_pkg::STS_OK, 32'h8000_5000, 0),
      mk(bfa_pkg::MODE_CLAIM, 0, 0, 32'h7FFF_FFFF, 0, 1, bfa_pkg::STS_USED, 0, 0),
      mk(bfa_pkg::MODE_CLAIM, 0, 0, 32'h9000_0000, 0, 1, bfa_pkg::STS_USED, 0, 0),
      mk(bfa_pkg::MODE_CLAIM, 0, 0, 32'h0000_0000, 0, 1, bfa_pkg::STS_USED, 0, 0),
      mk(bfa_pkg::MODE_FREE, 0, 0, 32'h8000_5000, 0, 1, bfa_pkg::STS_OK, 0, 0),
      mk(bfa_pkg::MODE_FREE, 0, 0, 32'hFFFF_FFFF, 0, 1, bfa_pkg::STS_USED, 0, 0),
      mk(bfa_pkg::MODE_QUERY, 0, 0, 32'h8000_0000, 0, 1, bfa_pkg::STS_OK, 0, 1),
      mk(bfa_pkg::MODE_QUERY, 0, 0, 32'h8000_5000, 0, 1, bfa_pkg::STS_OK, 0, 0),
      mk(bfa_pkg::MODE_QUERY, 0, 0, 32'h9000_0000, 0, 1, bfa_pkg::STS_OK, 0, 1),
      mk(bfa_pkg::MODE_RANGE, 0, 0, 32'h8000_1000, 32'h8000_0000, 1, bfa_pkg::STS_REV, 0, 0),
      mk(bfa_pkg::MODE_RANGE, 0, 0, 32'h8000_0000, 32'h8000_1FFF, 1, bfa_pkg::STS_OK, 0, 0),
      // partial range: last two frames freed, then out of bounds
      mk(bfa_pkg::MODE_RANGE, 0, 0, 32'h8FFF_E000, 32'h9000_2000, 1, bfa_pkg::STS_USED, 0, 0),
      mk(bfa_pkg::MODE_RANGE, 0, 0, 32'h8000_3000, 32'h8000_3000, 1, bfa_pkg::STS_OK, 0, 0),
      mk(MODE_BAD_LO, 0, 0, 0, 0, 1, bfa_pkg::STS_USED, 0, 0),
      mk(MODE_BAD_HI, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, bfa_pkg::STS_USED, 0, 0),
      mk(bfa_pkg::MODE_QUERY, 0, 0, 32'hFFFF_F000, 0, 0, bfa_pkg::STS_OK, 0, 0)
    };
    foreach (rows[i]) send_request(rows[i]);

    // fill the last domain word by word, then both search kinds must come up empty
    for (int i = 0; i < REGION / 32; i++)
      send_request(mk(bfa_pkg::MODE_ALLOC, DOMAINS - 1, MAX_RUN, 0, 0, 0,
                      bfa_pkg::STS_OK, 0, 0));
    send_request(mk(bfa_pkg::MODE_ALLOC, DOMAINS - 1, 1, 0, 0, 1, bfa_pkg::STS_NOFREE, 0, 0));
    send_request(mk(bfa_pkg::MODE_ALLOC, DOMAINS - 1, 5, 0, 0, 1, bfa_pkg::STS_NOFREE, 0, 0));
    send_request(mk(bfa_pkg::MODE_RANGE, 0, 0,
                    base_addr + (32'((DOMAINS - 1) * REGION + 64) << 12),
                    base_addr + (32'((DOMAINS - 1) * REGION + 200) << 12), 0,
                    bfa_pkg::STS_OK, 0, 0));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: drain_and_set_base(32'h0000_0000);
        1: drain_and_set_base(32'hFFFF_FFFF);
        2: drain_and_set_base($urandom & ~32'hFFF);
        default: drain_and_set_base(bfa_pkg::BASE_RESET);
      endcase
      idle_pct = (ph == 0) ? 11 : (ph == 1) ? 59 : 0;
      for (int i = 0; i < 16; i++) send_request(random_request());
    end

    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
